[hw/rtl/sactc_pkg.sv]
// Package with shared types, constants and helpers of the cache tag controller.
package sactc_pkg;

   localparam int NumSetsDefault   = 64;
   localparam int NumWaysDefault   = 4;
   localparam int LineBytesDefault = 64;
   localparam int AddrWidthDefault = 32;

   localparam logic ActRead          = 1'b0;
   localparam logic ActWrite         = 1'b1;
   localparam logic ModeWriteThrough = 1'b0;
   localparam logic ModeWriteBack    = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [1:0]  way;
      logic        victim_writeback;
      logic [31:0] victim_address;
      logic        fill_line;
      logic        store_line;
      logic [31:0] line_address;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_UPDATE
   } bk_state_type;

   // Floor of log2, worked out at elaboration.
   function automatic int flog2(input int n);
      int c;
      int v;
      c = 0;
      v = n;
      while (v > 1) begin
         v = v >> 1;
         c = c + 1;
      end
      return c;
   endfunction

endpackage

[hw/rtl/sactc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module sactc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/sactc_front.sv]
// Front end: accepts request beats and splits the address into set, tag and line base.
module sactc_front #(
   parameter int NUM_SETS   = 64,
   parameter int LINE_BYTES = 64,
   parameter int ADDR_WIDTH = 32,
   parameter int SET_W      = 6,
   parameter int TAG_W      = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  sactc_pkg::req_type  req_data,
   input  logic                req_push,
   output logic                req_full,
   output logic                q_valid,
   input  logic                q_take,
   output logic                q_write,
   output logic [SET_W-1:0]    q_set,
   output logic [TAG_W-1:0]    q_tag,
   output logic [31:0]         q_line
);
   import sactc_pkg::*;

   localparam int OB = flog2(LINE_BYTES);
   localparam int IB = flog2(NUM_SETS);
   localparam int TB = ADDR_WIDTH - IB - OB;

   // Two-entry queue of classified accesses.
   typedef struct packed {
      logic             wr;
      logic [SET_W-1:0] set;
      logic [TAG_W-1:0] tag;
      logic [31:0]      line;
   } ent_type;

   ent_type     ent_ff [2];
   ent_type     ent_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        rp_ff, rp_in, wp_ff, wp_in;
   logic [31:0] addr;
   logic        push_ok, take_ok;

   always_comb begin
      addr = req_data.address;
      if (ADDR_WIDTH < 32) begin
         addr = req_data.address & ((32'h1 << ADDR_WIDTH) - 32'h1);
      end
      ent_in.wr   = req_data.action;
      ent_in.set  = '0;
      if (IB > 0) begin
         ent_in.set = SET_W'(addr >> OB);
      end
      ent_in.tag  = '0;
      if (TB > 0) begin
         ent_in.tag = TAG_W'(addr >> (IB + OB));
      end
      ent_in.line = (addr >> OB) << OB;
   end

   assign req_full = (cnt_ff == 2'd2);
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (cnt_ff != 2'd0);
   assign take_ok  = q_take && q_valid;
   assign q_write  = ent_ff[rp_ff].wr;
   assign q_set    = ent_ff[rp_ff].set;
   assign q_tag    = ent_ff[rp_ff].tag;
   assign q_line   = ent_ff[rp_ff].line;

   always_comb begin
      cnt_in = cnt_ff + 2'(push_ok) - 2'(take_ok);
      rp_in  = take_ok ? !rp_ff : rp_ff;
      wp_in  = push_ok ? !wp_ff : wp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
      end
      if (push_ok) begin
         ent_ff[wp_ff] <= ent_in;
      end
   end
endmodule

[hw/rtl/sactc_back.sv]
// Back end: reads the set, resolves hit and victim, updates state and holds the result.
module sactc_back #(
   parameter int NUM_SETS   = 64,
   parameter int NUM_WAYS   = 4,
   parameter int LINE_BYTES = 64,
   parameter int SET_W      = 6,
   parameter int TAG_W      = 20,
   parameter int WAY_W      = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wb_mode,
   input  logic               q_valid,
   output logic               q_take,
   input  logic               q_write,
   input  logic [SET_W-1:0]   q_set,
   input  logic [TAG_W-1:0]   q_tag,
   input  logic [31:0]        q_line,
   output sactc_pkg::rsp_type rsp_data,
   output logic               rsp_empty,
   input  logic               rsp_pop
);
   import sactc_pkg::*;

   localparam int OB     = flog2(LINE_BYTES);
   localparam int IB     = flog2(NUM_SETS);
   localparam int ROW_W  = NUM_WAYS * (TAG_W + 1 + WAY_W);
   localparam int RAM_AW = $clog2(NUM_SETS > 1 ? NUM_SETS : 2);

   // One row per set: per way tag, dirty and rank; valid bits live in flops.
   logic [NUM_WAYS*TAG_W-1:0] tag_rd, tag_wr;
   logic [NUM_WAYS-1:0]       dty_rd, dty_wr;
   logic [NUM_WAYS*WAY_W-1:0] rnk_rd, rnk_wr;
   logic [ROW_W-1:0]          row_rd;
   logic [NUM_WAYS-1:0]       valid_ff [NUM_SETS];
   logic [NUM_WAYS-1:0]       vld, vld_new;

   bk_state_type st_ff, st_in;
   logic         wr_ff;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [31:0]  line_ff;
   rsp_type      out_ff, out_in;
   logic         full_ff, full_in;
   logic         ram_we;
   logic         ld_req;
   logic         found;
   logic [WAY_W-1:0] hw, vw, w;
   logic [WAY_W-1:0] rk [NUM_WAYS];
   logic [WAY_W-1:0] rnow;
   logic         have_inv;
   logic [63:0]  vaddr64;

   // The read address stays on the loaded set until the row is written back.
   sactc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (RAM_AW'(set_ff)),
      .wr_data ({tag_wr, dty_wr, rnk_wr}),
      .rd_addr (RAM_AW'(ld_req ? q_set : set_ff)),
      .rd_data (row_rd)
   );

   // Rows not yet written read as zero tag and rank = way; their dirty bits are not cleared.
   always_comb begin
      vld = valid_ff[set_ff];
      for (int i = 0; i < NUM_WAYS; i++) begin
         tag_rd[i*TAG_W +: TAG_W] = vld[i] ? row_rd[ROW_W-1-(NUM_WAYS-1-i)*TAG_W -: TAG_W]
                                           : '0;
         dty_rd[i] = row_rd[NUM_WAYS*WAY_W + i];
         rnk_rd[i*WAY_W +: WAY_W] = row_rd[i*WAY_W +: WAY_W];
         if (vld == '0) begin
            rnk_rd[i*WAY_W +: WAY_W] = WAY_W'(i);
         end
         rk[i] = rnk_rd[i*WAY_W +: WAY_W];
      end
   end

   always_comb begin
      found    = 1'b0;
      hw       = '0;
      have_inv = 1'b0;
      vw       = '0;
      for (int i = NUM_WAYS - 1; i >= 0; i--) begin
         if (vld[i] && tag_rd[i*TAG_W +: TAG_W] == tag_ff) begin
            found = 1'b1;
            hw    = WAY_W'(i);
         end
         if (!vld[i]) begin
            have_inv = 1'b1;
            vw       = WAY_W'(i);
         end
      end
      if (!have_inv) begin
         vw = '0;
         for (int i = 1; i < NUM_WAYS; i++) begin
            if (rk[i] < rk[vw]) begin
               vw = WAY_W'(i);
            end
         end
      end
      w    = found ? hw : vw;
      rnow = rk[w];
      tag_wr  = tag_rd;
      dty_wr  = dty_rd;
      vld_new = vld;
      for (int i = 0; i < NUM_WAYS; i++) begin
         rnk_wr[i*WAY_W +: WAY_W] = (rk[i] > rnow) ? rk[i] - WAY_W'(1) : rk[i];
      end
      rnk_wr[w*WAY_W +: WAY_W] = WAY_W'(NUM_WAYS - 1);
      if (found) begin
         if (wr_ff) begin
            dty_wr[w] = wb_mode;
         end
      end else begin
         tag_wr[w*TAG_W +: TAG_W] = tag_ff;
         vld_new[w] = 1'b1;
         dty_wr[w]  = wr_ff && wb_mode;
      end
      vaddr64 = (64'(tag_rd[w*TAG_W +: TAG_W]) << (IB + OB)) | (64'(set_ff) << OB);
      out_in.hit              = found;
      out_in.way              = 2'(w);
      out_in.victim_writeback = !found && vld[w] && dty_rd[w];
      out_in.victim_address   = out_in.victim_writeback ? vaddr64[31:0] : 32'h0;
      out_in.fill_line        = !found;
      out_in.store_line       = wr_ff && !wb_mode;
      out_in.line_address     = line_ff;
   end

   // A new access is read only when the result register is free.
   always_comb begin
      st_in   = st_ff;
      ld_req  = 1'b0;
      ram_we  = 1'b0;
      full_in = full_ff && !rsp_pop;
      case (st_ff)
         BK_IDLE: begin
            if (q_valid && !full_in) begin
               ld_req = 1'b1;
               st_in  = BK_READ;
            end
         end
         BK_READ: begin
            st_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            ram_we  = 1'b1;
            full_in = 1'b1;
            st_in   = BK_IDLE;
         end
         default: st_in = BK_IDLE;
      endcase
   end

   assign q_take    = ld_req;
   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= BK_IDLE;
         full_ff <= 1'b0;
         for (int s = 0; s < NUM_SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else begin
         st_ff   <= st_in;
         full_ff <= full_in;
         if (ram_we) begin
            valid_ff[set_ff] <= vld_new;
         end
      end
      if (ld_req) begin
         wr_ff   <= q_write;
         set_ff  <= q_set;
         tag_ff  <= q_tag;
         line_ff <= q_line;
      end
      if (ram_we) begin
         out_ff <= out_in;
      end
   end
endmodule

[hw/rtl/set_assoc_cache_tag_controller_unit.sv]
// Top level of the set-associative cache tag and replacement controller.
//
//   channel | ports                    | direction
//   request | push, full, req_data     | in
//   result  | pop, empty, rsp_data     | out
//   csr     | csr_we, csr_wdata        | in
//
// An access passes through the back-end steps queue pop with set read, tag compare
// and row write-back; a new beat is taken only after the last is written back and
// the result register is free or popped. Set rows are written once per access.
// Reset clears all valid bits at once; no sweep is needed. Mode resets to write-back.
// The request queue holds two beats; a full result register stalls the back end.
module set_assoc_cache_tag_controller_unit #(
   parameter int NUM_SETS   = sactc_pkg::NumSetsDefault,
   parameter int NUM_WAYS   = sactc_pkg::NumWaysDefault,
   parameter int LINE_BYTES = sactc_pkg::LineBytesDefault,
   parameter int ADDR_WIDTH = sactc_pkg::AddrWidthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  sactc_pkg::req_type req_data,
   output logic               empty,
   input  logic               pop,
   output sactc_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic               csr_wdata
);
   import sactc_pkg::*;

   localparam int OB    = flog2(LINE_BYTES);
   localparam int IB    = flog2(NUM_SETS);
   localparam int TB    = ADDR_WIDTH - IB - OB;
   localparam int SET_W = (IB > 0) ? IB : 1;
   localparam int TAG_W = (TB > 0) ? TB : 1;
   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

   logic             mode_ff, mode_in;
   logic             q_valid, q_take, q_write;
   logic [SET_W-1:0] q_set;
   logic [TAG_W-1:0] q_tag;
   logic [31:0]      q_line;

   assign mode_in = csr_we ? csr_wdata : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeWriteBack;
      end else begin
         mode_ff <= mode_in;
      end
   end

   sactc_front #(
      .NUM_SETS(NUM_SETS), .LINE_BYTES(LINE_BYTES), .ADDR_WIDTH(ADDR_WIDTH),
      .SET_W(SET_W), .TAG_W(TAG_W)
   ) u_front (
      .clock(clock), .reset(reset), .req_data(req_data), .req_push(push),
      .req_full(full), .q_valid(q_valid), .q_take(q_take), .q_write(q_write),
      .q_set(q_set), .q_tag(q_tag), .q_line(q_line)
   );

   sactc_back #(
      .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .LINE_BYTES(LINE_BYTES),
      .SET_W(SET_W), .TAG_W(TAG_W), .WAY_W(WAY_W)
   ) u_back (
      .clock(clock), .reset(reset), .wb_mode(mode_ff), .q_valid(q_valid),
      .q_take(q_take), .q_write(q_write), .q_set(q_set), .q_tag(q_tag),
      .q_line(q_line), .rsp_data(rsp_data), .rsp_empty(empty), .rsp_pop(pop)
   );

   a_fill_not_hit: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.fill_line != rsp_data.hit))
      else $error("fill and hit disagree");

   a_wb_needs_miss: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.victim_writeback) |-> rsp_data.fill_line)
      else $error("write-back without a miss");

   a_take_needs_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("back end took from an empty queue");
endmodule
